/* hw/rtl/srm_pkg.sv */
`timescale 1ns / 1ps

package srm_pkg;

    // Width of the ports' payload fields.
    localparam int FIELD_W = 64;

    // Width at which the arithmetic is done; the low DATA_WIDTH bits of each input are used.
    localparam int DATA_WIDTH = 64;

    // Most negative value at DATA_WIDTH bits.
    localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Register index of the mode register, taken from paddr[2].
    localparam logic REG_MODE = 1'b0;

    // Mode codes.
    localparam logic MODE_TRUNC = 1'b0;
    localparam logic MODE_FLOOR = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NULL     = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // Word handed from one stage of the divider chain to the next.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] rem;   // partial remainder
        logic [DATA_WIDTH-1:0] num;   // dividend magnitude bits not yet shifted in
        logic [DATA_WIDTH-1:0] den;   // divisor magnitude
        logic                  neg_a; // dividend is negative
        logic                  neg_b; // divisor is negative
        logic                  mode;  // mode captured when the word was accepted
        status_t               status;
    } word_t;

endpackage

/* hw/rtl/srm_in_if.sv */
`timescale 1ns / 1ps

interface srm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [srm_pkg::FIELD_W-1:0] dividend;
    logic signed [srm_pkg::FIELD_W-1:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink (input valid, input dividend, input divisor, output ready);
endinterface

/* hw/rtl/srm_out_if.sv */
`timescale 1ns / 1ps

interface srm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [srm_pkg::FIELD_W-1:0] remainder;
    logic [1:0]                          status;

    modport source (output valid, output remainder, output status, input ready);
    modport sink (input valid, input remainder, input status, output ready);
endinterface

/* hw/rtl/srm_prep.sv */
`timescale 1ns / 1ps

module srm_prep (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                mode,
    srm_in_if.sink              din,
    output logic                dn_valid,
    output srm_pkg::word_t      dn_word,
    input  logic                dn_ready
);

    logic                              valid_reg;
    srm_pkg::word_t                    word_reg;
    srm_pkg::word_t                    word_next;
    logic [srm_pkg::DATA_WIDTH-1:0]    a;
    logic [srm_pkg::DATA_WIDTH-1:0]    b;
    logic                              load;

    // The stage takes a word when it is empty or its word moves on.
    assign din.ready = !valid_reg || dn_ready;
    assign load      = din.valid && din.ready;

    assign a = din.dividend[srm_pkg::DATA_WIDTH-1:0];
    assign b = din.divisor[srm_pkg::DATA_WIDTH-1:0];

    // Split both operands into sign and magnitude and flag the special cases.
    always_comb
    begin
        word_next.rem   = '0;
        word_next.neg_a = a[srm_pkg::DATA_WIDTH-1];
        word_next.neg_b = b[srm_pkg::DATA_WIDTH-1];
        word_next.num   = word_next.neg_a ? (~a + 1'b1) : a;
        word_next.den   = word_next.neg_b ? (~b + 1'b1) : b;
        word_next.mode  = mode;
        if (b == '0)
        begin
            word_next.status = srm_pkg::ST_NULL;
        end
        else if (b == '1 && a == srm_pkg::MIN_VAL)
        begin
            word_next.status = srm_pkg::ST_OVERFLOW;
        end
        else
        begin
            word_next.status = srm_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (din.ready)
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

`ifndef ASSERT_OFF
    // A zero divisor is flagged as null in the word that enters the chain.
    a_zero_div_null: assert property (@(posedge clk) disable iff (!rst_n)
        load && b == '0 |=> valid_reg && word_reg.status == srm_pkg::ST_NULL)
        else $error("zero divisor not flagged as null");
`endif

endmodule

/* hw/rtl/srm_cell.sv */
`timescale 1ns / 1ps

module srm_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    input  srm_pkg::word_t up_word,
    output logic           up_ready,
    output logic           dn_valid,
    output srm_pkg::word_t dn_word,
    input  logic           dn_ready
);

    logic                            valid_reg;
    srm_pkg::word_t                  word_reg;
    srm_pkg::word_t                  word_next;
    logic [srm_pkg::DATA_WIDTH:0]    trial;
    logic [srm_pkg::DATA_WIDTH:0]    den_ext;
    logic [srm_pkg::DATA_WIDTH:0]    diff;

    assign up_ready = !valid_reg || dn_ready;

    // One restoring step: shift in the next dividend bit, subtract the divisor if it fits.
    assign trial   = {up_word.rem, up_word.num[srm_pkg::DATA_WIDTH-1]};
    assign den_ext = {1'b0, up_word.den};
    assign diff    = trial - den_ext;

    always_comb
    begin
        word_next     = up_word;
        word_next.num = {up_word.num[srm_pkg::DATA_WIDTH-2:0], 1'b0};
        if (trial >= den_ext)
        begin
            word_next.rem = diff[srm_pkg::DATA_WIDTH-1:0];
        end
        else
        begin
            word_next.rem = trial[srm_pkg::DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

`ifndef ASSERT_OFF
    // For a word with OK status, the partial remainder stays below the divisor at every step.
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && word_reg.status == srm_pkg::ST_OK |-> word_reg.rem < word_reg.den)
        else $error("partial remainder not below divisor");
`endif

endmodule

/* hw/rtl/srm_fix.sv */
`timescale 1ns / 1ps

module srm_fix (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    input  srm_pkg::word_t up_word,
    output logic           up_ready,
    srm_out_if.source      dout
);

    logic                              a_valid_reg;
    logic [srm_pkg::DATA_WIDTH-1:0]    a_mag_reg;
    logic [srm_pkg::DATA_WIDTH-1:0]    a_mag_next;
    logic                              a_neg_reg;
    logic                              a_neg_next;
    srm_pkg::status_t                  a_status_reg;
    logic                              a_ready;
    logic                              floor_adj;

    logic                              b_valid_reg;
    logic [srm_pkg::FIELD_W-1:0]       b_rem_reg;
    logic [srm_pkg::FIELD_W-1:0]       b_rem_next;
    srm_pkg::status_t                  b_status_reg;
    logic [srm_pkg::DATA_WIDTH-1:0]    value;

    assign a_ready  = !b_valid_reg || dout.ready;
    assign up_ready = !a_valid_reg || a_ready;

    // Floored mode moves a nonzero remainder over to the divisor's side when the operand signs differ.
    assign floor_adj = up_word.mode == srm_pkg::MODE_FLOOR && up_word.rem != '0
                       && up_word.neg_a != up_word.neg_b;

    always_comb
    begin
        if (up_word.status != srm_pkg::ST_OK)
        begin
            a_mag_next = '0;
            a_neg_next = 1'b0;
        end
        else if (floor_adj)
        begin
            a_mag_next = up_word.den - up_word.rem;
            a_neg_next = up_word.neg_b;
        end
        else
        begin
            a_mag_next = up_word.rem;
            a_neg_next = up_word.neg_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            a_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            a_mag_reg    <= a_mag_next;
            a_neg_reg    <= a_neg_next;
            a_status_reg <= up_word.status;
        end
    end

    // Apply the sign and widen to the port width; this is the output register.
    assign value      = a_neg_reg ? (~a_mag_reg + 1'b1) : a_mag_reg;
    assign b_rem_next = srm_pkg::FIELD_W'(signed'(value));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && a_valid_reg)
        begin
            b_rem_reg    <= b_rem_next;
            b_status_reg <= a_status_reg;
        end
    end

    assign dout.valid     = b_valid_reg;
    assign dout.remainder = b_rem_reg;
    assign dout.status    = b_status_reg;

`ifndef ASSERT_OFF
    // A word flagged null or overflow carries a zero remainder.
    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && b_status_reg != srm_pkg::ST_OK |-> b_rem_reg == '0)
        else $error("nonzero remainder with error status");

    // The remainder that is adjusted stays below the divisor's magnitude.
    a_floor_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && up_word.status == srm_pkg::ST_OK && floor_adj
        |-> up_word.den > up_word.rem)
        else $error("floored adjustment out of range");
`endif

endmodule

/* hw/rtl/signed_remainder_mod_pmod_core.sv */
`timescale 1ns / 1ps

// Channel | Direction | Payload                         | Handshake
// din     | in        | dividend[63:0], divisor[63:0]   | valid / ready
// dout    | out       | remainder[63:0], status[1:0]    | valid / ready
// apb     | in        | mode register at byte address 0 | psel / penable, pready = 1
//
// One word is accepted per cycle while the chain is not stalled; each word passes through
// one operand stage, one divider cell per dividend bit and two sign stages before it leaves.
// Each stage has its own valid bit and ready ripples back through the chain, so bubbles
// close up and input keeps being taken while a result waits at the output register,
// until all DATA_WIDTH + 3 stages hold a word.
// Reset clears all valid bits and sets mode to truncated.

module signed_remainder_mod_pmod_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    srm_in_if.sink      din,
    srm_out_if.source   dout
);

    localparam int NCELL = srm_pkg::DATA_WIDTH;

    logic                mode_reg;
    logic                wr_en;
    logic                ch_valid [NCELL+1];
    logic                ch_ready [NCELL+1];
    srm_pkg::word_t      ch_word  [NCELL+1];

    // Configuration port: writes complete in the access cycle.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= srm_pkg::MODE_TRUNC;
        end
        else if (wr_en && paddr[2] == srm_pkg::REG_MODE)
        begin
            mode_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == srm_pkg::REG_MODE) ? 32'(mode_reg) : '0;

    // Operand stage.
    srm_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode_reg),
        .din      (din),
        .dn_valid (ch_valid[0]),
        .dn_word  (ch_word[0]),
        .dn_ready (ch_ready[0])
    );

    // Divider chain, one cell per dividend bit.
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        srm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (ch_valid[i]),
            .up_word  (ch_word[i]),
            .up_ready (ch_ready[i]),
            .dn_valid (ch_valid[i+1]),
            .dn_word  (ch_word[i+1]),
            .dn_ready (ch_ready[i+1])
        );
    end

    // Sign correction and output register.
    srm_fix u_fix (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (ch_valid[NCELL]),
        .up_word  (ch_word[NCELL]),
        .up_ready (ch_ready[NCELL]),
        .dout     (dout)
    );

endmodule

/* bench/signed_remainder_mod_pmod_core_tb.sv */
`timescale 1ns / 1ps

module signed_remainder_mod_pmod_core_tb;

    // Run length guards.
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LATENCY     = srm_pkg::DATA_WIDTH + 3;
    localparam int TAIL_CYCLES = LATENCY + 40;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    // Register addresses: the mode register and an index past it.
    localparam logic [2:0] ADDR_MODE  = {srm_pkg::REG_MODE, 2'b00};
    localparam logic [2:0] ADDR_SPARE = {~srm_pkg::REG_MODE, 2'b00};

    // Extremes of a 64-bit operand.
    localparam logic signed [srm_pkg::FIELD_W-1:0] S_MIN =
        {1'b1, {(srm_pkg::FIELD_W-1){1'b0}}};
    localparam logic signed [srm_pkg::FIELD_W-1:0] S_MAX =
        {1'b0, {(srm_pkg::FIELD_W-1){1'b1}}};

    typedef struct {
        logic signed [srm_pkg::FIELD_W-1:0] remainder;
        srm_pkg::status_t                   status;
    } rem_result_t;

    // Remainder predictor and queue of remainders still owed by the block.
    class remainder_scoreboard;
        rem_result_t owed_q [$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        function rem_result_t predict(logic signed [srm_pkg::FIELD_W-1:0] a_in,
                                      logic signed [srm_pkg::FIELD_W-1:0] b_in, logic m);
            logic signed [srm_pkg::DATA_WIDTH-1:0] a;
            logic signed [srm_pkg::DATA_WIDTH-1:0] b;
            logic signed [srm_pkg::DATA_WIDTH-1:0] r;
            rem_result_t                           res;
            a = a_in[srm_pkg::DATA_WIDTH-1:0];
            b = b_in[srm_pkg::DATA_WIDTH-1:0];
            res.remainder = '0;
            res.status    = srm_pkg::ST_OK;
            if (b == '0)
            begin
                res.status = srm_pkg::ST_NULL;
            end
            else if (b == '1 && a == srm_pkg::MIN_VAL)
            begin
                res.status = srm_pkg::ST_OVERFLOW;
            end
            else
            begin
                r = a % b;
                // Floored mode moves a remainder of the wrong sign over by one divisor.
                if (m == srm_pkg::MODE_FLOOR && r != '0
                    && r[srm_pkg::DATA_WIDTH-1] != b[srm_pkg::DATA_WIDTH-1])
                    r = r + b;
                res.remainder = srm_pkg::FIELD_W'(r);
            end
            return res;
        endfunction

        function void note_operands(logic signed [srm_pkg::FIELD_W-1:0] a_in,
                                    logic signed [srm_pkg::FIELD_W-1:0] b_in, logic m);
            owed_q.push_back(predict(a_in, b_in, m));
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch: %s", msg);
        endfunction

        function void check_result(logic signed [srm_pkg::FIELD_W-1:0] rem, logic [1:0] st);
            rem_result_t want;
            if (owed_q.size() == 0)
            begin
                report($sformatf("unexpected word remainder=%h status=%0d", rem, st));
                return;
            end
            want = owed_q.pop_front();
            if (rem !== want.remainder)
                report($sformatf("remainder expected %h actual %h", want.remainder, rem));
            if (st !== want.status)
                report($sformatf("status expected %0d actual %0d", want.status, st));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    srm_in_if  din_if ();
    srm_out_if dout_if ();

    signed_remainder_mod_pmod_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .din     (din_if),
        .dout    (dout_if)
    );

    remainder_scoreboard sb;
    logic                cur_mode;
    bit                  in_calm;
    bit                  out_calm;
    bit                  hold_pending;
    int                  cycles;

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [srm_pkg::FIELD_W-1:0] rand_wide();
        return {$urandom, $urandom};
    endfunction

    function automatic logic signed [srm_pkg::FIELD_W-1:0] rand_small();
        int v;
        v = int'($urandom_range(0, 40)) - 20;
        return srm_pkg::FIELD_W'(v);
    endfunction

    // Operand pairs from a mix of classes: wide, small, zero divisor, extremes, exact multiples, powers of two.
    task automatic gen_pair(output logic signed [srm_pkg::FIELD_W-1:0] a,
                            output logic signed [srm_pkg::FIELD_W-1:0] b);
        logic signed [srm_pkg::FIELD_W-1:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                a = rand_wide();
                b = rand_wide();
            end
            3:
            begin
                a = rand_small();
                b = rand_small();
            end
            4:
            begin
                a = ($urandom_range(0, 1) != 0) ? rand_wide() : rand_small();
                b = '0;
            end
            5:
            begin
                case ($urandom_range(0, 3))
                    0: a = S_MIN;
                    1: a = S_MAX;
                    2: a = S_MIN + rand_small() + 64'sd20;
                    default: a = S_MAX - rand_small() - 64'sd20;
                endcase
                case ($urandom_range(0, 3))
                    0: b = -64'sd1;
                    1: b = 64'sd1;
                    2: b = rand_small();
                    default: b = rand_wide();
                endcase
            end
            6:
            begin
                b = ($urandom_range(0, 1) != 0) ? rand_small() : rand_wide() >>> 32;
                k = ($urandom_range(0, 1) != 0) ? rand_small() : rand_wide() >>> 32;
                a = b * k;
            end
            7:
            begin
                b = 64'sd1 <<< $urandom_range(0, srm_pkg::FIELD_W - 1);
                if ($urandom_range(0, 1) != 0)
                    b = -b;
                a = rand_wide();
            end
            8:
            begin
                a = rand_wide();
                b = rand_small();
            end
            default:
            begin
                a = rand_small();
                b = rand_wide();
            end
        endcase
    endtask

    // Offer one word after a random gap and wait until it is taken.
    task automatic send_word(input logic signed [srm_pkg::FIELD_W-1:0] a,
                             input logic signed [srm_pkg::FIELD_W-1:0] b);
        int gap;
        gap = pick_gap(in_calm);
        if (gap > 0)
        begin
            din_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_if.valid    <= 1'b1;
        din_if.dividend <= a;
        din_if.divisor  <= b;
        do
            @(posedge clk);
        while (!din_if.ready);
        sb.note_operands(a, b, cur_mode);
    endtask

    task automatic end_phase();
        din_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == srm_pkg::REG_MODE)
            cur_mode = data[0];
    endtask

    // Extremes, each sign pattern, exact division, zero divisor and overflow.
    task automatic run_directed();
        send_word(S_MIN, -64'sd1);
        send_word(S_MIN, '0);
        send_word(S_MAX, S_MIN);
        send_word(S_MIN, S_MAX);
        send_word(S_MIN, S_MIN);
        send_word(64'sd7, 64'sd3);
        send_word(-64'sd7, 64'sd3);
        send_word(64'sd7, -64'sd3);
        send_word(-64'sd7, -64'sd3);
        send_word(-64'sd1, S_MAX);
        send_word(S_MAX, -64'sd1);
        send_word(-64'sd6, 64'sd3);
    endtask

    task automatic run_random(input int count);
        logic signed [srm_pkg::FIELD_W-1:0] a;
        logic signed [srm_pkg::FIELD_W-1:0] b;
        repeat (count)
        begin
            gen_pair(a, b);
            send_word(a, b);
        end
    endtask

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && dout_if.valid && dout_if.ready)
            sb.check_result(dout_if.remainder, dout_if.status);
    end

    // Receiver ready: random stalls, plus one long hold-off on request.
    initial
    begin : sink_ready
        int gap;
        dout_if.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                dout_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = pick_gap(out_calm);
                if (gap > 0)
                begin
                    dout_if.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                dout_if.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Watchdog.
    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Main sequence.
    initial
    begin : main_seq
        sb           = new();
        cur_mode     = srm_pkg::MODE_TRUNC;
        in_calm      = 1'b0;
        out_calm     = 1'b0;
        hold_pending = 1'b0;
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        din_if.valid    <= 1'b0;
        din_if.dividend <= '0;
        din_if.divisor  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words in truncated mode straight after reset, then in floored mode.
        run_directed();
        end_phase();
        apb_write(ADDR_MODE, {31'd0, srm_pkg::MODE_FLOOR});
        run_directed();
        end_phase();

        // A write past the mode register must leave floored mode in place.
        apb_write(ADDR_SPARE, 32'h0000_0000);
        run_random(250);
        end_phase();

        // Upper data bits are ignored; then the output stalls while the input keeps coming.
        apb_write(ADDR_MODE, 32'hFFFF_FFFE);
        run_random(100);
        in_calm      = 1'b1;
        hold_pending = 1'b1;
        run_random(220);
        in_calm = 1'b0;
        end_phase();

        // Sender has waited for every result; now a stretch with no idling on either side.
        apb_write(ADDR_MODE, 32'h8000_0001);
        in_calm  = 1'b1;
        out_calm = 1'b1;
        run_random(250);
        end_phase();
        in_calm  = 1'b0;
        out_calm = 1'b0;

        apb_write(ADDR_MODE, {31'd0, srm_pkg::MODE_TRUNC});
        run_random(250);
        end_phase();

        apb_write(ADDR_MODE, {31'd0, srm_pkg::MODE_FLOOR});
        run_random(230);
        end_phase();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
